/* rtl/bpf_pkg.sv */
// ----------------------------------------------------------------------------
// bpf_pkg
// Shared constants and types for the band-pass FIR filter and its
// multiply-accumulate unit.
// ----------------------------------------------------------------------------
package bpf_pkg;

  // Default filter size and operand widths.
  localparam int TAPS_DEF        = 29;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COEF_BITS_DEF   = 18;

  // Coefficients are Q2.16, so the sum of products carries 16 fraction bits.
  localparam int FRAC_BITS = 16;

  // The tap index field of a load item is always 5 bits wide.
  localparam int CIDX_W = 5;

  // Item kinds carried on the input tuser bit.
  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_LOAD   = 1'b1
  } bpf_cmd_t;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clr;  // preload the accumulator with the rounding constant
    logic vld;  // operands on the inputs form one product term
  } bpf_mac_ctl_t;

endpackage

/* rtl/bpf_mac.sv */
// ----------------------------------------------------------------------------
// bpf_mac
// Shared multiply-accumulate unit: one registered product per cycle, added
// into a wide accumulator that starts at the rounding constant.
// ----------------------------------------------------------------------------
module bpf_mac #(
  parameter int SAMPLE_BITS = bpf_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = bpf_pkg::COEF_BITS_DEF,
  parameter int ACC_W       = 40
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bpf_pkg::bpf_mac_ctl_t      ctl,
  input  logic signed [SAMPLE_BITS-1:0] smp,
  input  logic signed [COEF_BITS-1:0]   coef,
  output logic signed [ACC_W-1:0]       acc,
  output logic                       busy
);
  import bpf_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam logic signed [ACC_W-1:0] ROUND_K = ACC_W'(1) <<< (FRAC_BITS - 1);

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_vld_r;
  logic signed [ACC_W-1:0]  acc_r;

  // Product stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctl.vld;
    end
    prod_r <= smp * coef;
  end

  // Accumulate stage; the clear preloads half an output LSB for rounding.
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= ROUND_K;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign acc  = acc_r;
  assign busy = prod_vld_r;

endmodule

/* rtl/band_pass_fir_filter.sv */
// ----------------------------------------------------------------------------
// band_pass_fir_filter
// Direct-form FIR filter with loadable Q2.16 coefficients, rounded and
// saturated output, and block-based restart of the window fill count.
// ----------------------------------------------------------------------------
// A load item or a sample that does not yet complete the window is taken
// while idle. A sample that completes it is accepted, swept over every tap
// through the single shared multiply-accumulate unit, and drained through
// the memory read, product and accumulate registers before the result is
// loaded into the output register. The input stays not ready during that
// sweep. A finished result waits in the output register while the next
// item is taken, and the sweep only stalls at its end if that register is
// still full.
module band_pass_fir_filter #(
  parameter int TAPS        = bpf_pkg::TAPS_DEF,
  parameter int SAMPLE_BITS = bpf_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = bpf_pkg::COEF_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // Input channel.
  input  logic in_tvalid,
  output logic in_tready,
  // tdata: sample, coef_index, coef_value (lowest bits first), zero padded.
  input  logic [((SAMPLE_BITS + bpf_pkg::CIDX_W + COEF_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  input  logic in_tuser,  // cmd
  input  logic in_tlast,  // last
  // Result channel.
  output logic out_tvalid,
  input  logic out_tready,
  // tdata: filtered, zero padded.
  output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  output logic out_tuser,  // clipped
  output logic out_tlast   // block_end
);
  import bpf_pkg::*;

  localparam int OUT_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int IDX_W  = $clog2(TAPS);
  localparam int FILL_W = $clog2(TAPS + 1);
  localparam int SUM_W  = SAMPLE_BITS + COEF_BITS + $clog2(TAPS) + 1;
  localparam int MIN_W  = FRAC_BITS + SAMPLE_BITS + 2;
  localparam int ACC_W  = (SUM_W > MIN_W) ? SUM_W : MIN_W;
  localparam int YW     = ACC_W - FRAC_BITS;

  localparam logic signed [YW-1:0] Y_MAX = YW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [YW-1:0] Y_MIN = -Y_MAX - YW'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  state_t state_r;

  // Input field unpacking.
  logic                          in_fire;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic [CIDX_W-1:0]             in_cidx;
  logic signed [COEF_BITS-1:0]   in_coef;

  assign in_fire   = in_tvalid && in_tready;
  assign in_sample = in_tdata[SAMPLE_BITS-1:0];
  assign in_cidx   = in_tdata[SAMPLE_BITS +: CIDX_W];
  assign in_coef   = in_tdata[SAMPLE_BITS + CIDX_W +: COEF_BITS];

  // Sample ring buffer and coefficient store.
  logic [SAMPLE_BITS-1:0] smp_mem [TAPS];
  logic [COEF_BITS-1:0]   coef_mem [TAPS];
  logic [TAPS-1:0]        coef_vld_r;

  logic [IDX_W-1:0]  wptr_r;
  logic [IDX_W-1:0]  wptr_nxt;
  logic [IDX_W-1:0]  rptr_r;
  logic [IDX_W-1:0]  tap_r;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_inc;
  logic              full_w;
  logic              last_r;

  logic                          smp_wr;
  logic                          coef_wr;
  logic                          rd_vld_r;
  logic signed [SAMPLE_BITS-1:0] smp_rd_r;
  logic signed [COEF_BITS-1:0]   coef_rd_r;
  logic                          coef_ok_r;
  logic signed [COEF_BITS-1:0]   coef_op;

  assign smp_wr   = in_fire && (in_tuser == CMD_SAMPLE);
  assign coef_wr  = in_fire && (in_tuser == CMD_LOAD) && (32'(in_cidx) < 32'(TAPS));
  assign wptr_nxt = (wptr_r == IDX_W'(TAPS - 1)) ? '0 : wptr_r + IDX_W'(1);
  assign fill_inc = (fill_r < FILL_W'(TAPS)) ? fill_r + FILL_W'(1) : fill_r;
  assign full_w   = (fill_inc == FILL_W'(TAPS));

  // Sample memory: the newest sample goes one slot past the previous one.
  always_ff @(posedge clk) begin
    if (smp_wr) begin
      smp_mem[wptr_nxt] <= in_sample;
    end
    smp_rd_r <= smp_mem[rptr_r];
  end

  // Coefficient memory, read by tap number.
  always_ff @(posedge clk) begin
    if (coef_wr) begin
      coef_mem[IDX_W'(in_cidx)] <= in_coef;
    end
    coef_rd_r <= coef_mem[tap_r];
  end

  // Coefficients never loaded since reset read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0;
    end else if (coef_wr) begin
      coef_vld_r[IDX_W'(in_cidx)] <= 1'b1;
    end
    coef_ok_r <= coef_vld_r[tap_r];
  end

  assign coef_op = coef_ok_r ? coef_rd_r : '0;

  // Shared multiply-accumulate unit.
  bpf_mac_ctl_t           mac_ctl;
  logic signed [ACC_W-1:0] mac_acc;
  logic                   mac_busy;

  assign mac_ctl.clr = smp_wr && full_w;
  assign mac_ctl.vld = rd_vld_r;

  bpf_mac #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEF_BITS  (COEF_BITS),
    .ACC_W      (ACC_W)
  ) u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (mac_ctl),
    .smp  (smp_rd_r),
    .coef (coef_op),
    .acc  (mac_acc),
    .busy (mac_busy)
  );

  // Rounding is already in the accumulator; drop the fraction and saturate.
  logic signed [YW-1:0]          y_full;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic                          y_clip;
  logic                          pipe_busy;
  logic                          out_free;

  assign y_full = mac_acc[ACC_W-1:FRAC_BITS];

  always_comb begin
    y_sat  = y_full[SAMPLE_BITS-1:0];
    y_clip = 1'b0;
    if (y_full > Y_MAX) begin
      y_sat  = Y_MAX[SAMPLE_BITS-1:0];
      y_clip = 1'b1;
    end else if (y_full < Y_MIN) begin
      y_sat  = Y_MIN[SAMPLE_BITS-1:0];
      y_clip = 1'b1;
    end
  end

  assign pipe_busy = rd_vld_r || mac_busy;

  // Output register.
  logic                   out_vld_r;
  logic [SAMPLE_BITS-1:0] out_data_r;
  logic                   out_clip_r;
  logic                   out_last_r;
  logic                   out_load;

  assign out_free = !out_vld_r || out_tready;
  assign out_load = (state_r == ST_DRAIN) && !pipe_busy && out_free;

  // Sequencer: window bookkeeping, tap sweep and result hand-off.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      wptr_r    <= '0;
      rptr_r    <= '0;
      tap_r     <= '0;
      fill_r    <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      last_r    <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == ST_RUN);
      // A new result fills the output register; a taken result empties it.
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (smp_wr) begin
            wptr_r <= wptr_nxt;
            rptr_r <= wptr_nxt;
            tap_r  <= '0;
            last_r <= in_tlast;
            fill_r <= in_tlast ? '0 : fill_inc;
            if (full_w) begin
              state_r <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          rptr_r <= (rptr_r == '0) ? IDX_W'(TAPS - 1) : rptr_r - IDX_W'(1);
          tap_r  <= tap_r + IDX_W'(1);
          if (tap_r == IDX_W'(TAPS - 1)) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (out_load) begin
            out_data_r <= y_sat;
            out_clip_r <= y_clip;
            out_last_r <= last_r;
            state_r    <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_W'(out_data_r);
  assign out_tuser  = out_clip_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  // A sample that completes the window starts the tap sweep.
  a_sweep_start : assert property (@(posedge clk) disable iff (!rst_n)
    (smp_wr && full_w) |=> (state_r == ST_RUN))
    else $error("full window did not start the tap sweep");

  // The fill count never passes the number of taps.
  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(TAPS))
    else $error("fill count exceeds tap count");

  // Nothing is left in the arithmetic pipeline once the block is idle.
  a_idle_empty : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pipe_busy)
    else $error("pipeline busy while idle");

  // A drained sweep with a free output register delivers its result.
  a_result_out : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN && !pipe_busy && out_free) |=> (out_vld_r && state_r == ST_IDLE))
    else $error("drained sweep did not deliver a result");

  // Only the sweep feeds operands into the multiply-accumulate unit.
  a_operands : assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> ($past(state_r) == ST_RUN))
    else $error("operands issued outside the tap sweep");
`endif

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for band_pass_fir_filter
// Drives coefficient loads and sample items through the input stream. Each
// expected output comes from a typed row or a behavioral FIR model kept
// in step with every accepted item. A short directed table comes first, then
// random coefficient sets and sample blocks, with idle bursts on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import bpf_pkg::*;

  localparam int TAPS        = bpf_pkg::TAPS_DEF;
  localparam int SAMPLE_BITS = bpf_pkg::SAMPLE_BITS_DEF;
  localparam int COEF_BITS   = bpf_pkg::COEF_BITS_DEF;
  localparam int IN_W  = ((SAMPLE_BITS + CIDX_W + COEF_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;

  localparam int ITEMS_TOTAL  = 1150;
  localparam int CALM_ITEMS   = 150;   // no idling over the final items
  localparam int PAUSE_AT     = 600;   // sender waits for all outputs here
  localparam int HOLD_AT      = 80;    // long receiver hold-off after this many outputs
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 2 * (TAPS + 4);
  localparam int STALL_LIMIT  = 4000;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          clipped;
    logic                          block_end;
  } fir_out_t;

  typedef struct {
    bpf_cmd_t                      cmd;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic [CIDX_W-1:0]             cidx;
    logic signed [COEF_BITS-1:0]   cval;
    logic                          lst;
    int                            rep;
    bit                            typed;
    fir_out_t                      res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  // Model state: newest sample at position 0.
  logic signed [SAMPLE_BITS-1:0] hist_line [TAPS];
  logic signed [COEF_BITS-1:0]   coef_bank [TAPS];
  int unsigned                   window_cnt;

  fir_out_t  pending_q [$];
  stim_row_t stim_table [$];

  int  n_errors = 0;
  int  n_items = 0;
  int  n_loads = 0;
  int  n_outputs = 0;
  int  n_clipped = 0;
  int  n_block_ends = 0;
  int  stall_cnt = 0;
  bit  calm = 1'b0;

  band_pass_fir_filter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Advance the FIR model by one accepted item; returns 1 when it yields an output.
  function automatic bit fir_advance(input bpf_cmd_t cmd,
                                     input logic signed [SAMPLE_BITS-1:0] smp,
                                     input logic [CIDX_W-1:0] cidx,
                                     input logic signed [COEF_BITS-1:0] cval,
                                     input logic lst, output fir_out_t res);
    longint acc;
    longint y;
    longint max_y;
    longint min_y;
    bit     full;
    acc = 0;
    max_y = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    min_y = -max_y - 1;
    res = '{filtered: '0, clipped: 1'b0, block_end: 1'b0};
    if (cmd == CMD_LOAD) begin
      if (cidx < TAPS) coef_bank[cidx] = cval;
      return 1'b0;
    end
    for (int i = TAPS - 1; i > 0; i--) hist_line[i] = hist_line[i-1];
    hist_line[0] = smp;
    if (window_cnt < TAPS) window_cnt++;
    full = (window_cnt >= TAPS);
    if (lst) window_cnt = 0;
    if (!full) return 1'b0;
    for (int i = 0; i < TAPS; i++) acc += longint'(hist_line[i]) * longint'(coef_bank[i]);
    // Round half up at the binary point, then saturate.
    y = (acc + (64'sd1 <<< (bpf_pkg::FRAC_BITS - 1))) >>> bpf_pkg::FRAC_BITS;
    if (y > max_y) begin
      y = max_y;
      res.clipped = 1'b1;
    end else if (y < min_y) begin
      y = min_y;
      res.clipped = 1'b1;
    end
    res.filtered = y[SAMPLE_BITS-1:0];
    res.block_end = lst;
    return 1'b1;
  endfunction

  // Offer one item with an optional idle burst before it, wait for acceptance,
  // and record the output it should produce.
  task automatic send_item(input bpf_cmd_t cmd, input logic signed [SAMPLE_BITS-1:0] smp,
                           input logic [CIDX_W-1:0] cidx,
                           input logic signed [COEF_BITS-1:0] cval, input logic lst,
                           input bit typed, input fir_out_t typed_res);
    fir_out_t res;
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tlast  <= lst;
    in_tdata  <= IN_W'({cval, cidx, smp});
    do @(posedge clk); while (!in_tready);
    n_items++;
    if (cmd == CMD_LOAD) n_loads++;
    if (fir_advance(cmd, smp, cidx, cval, lst, res)) pending_q.push_back(typed ? typed_res : res);
  endtask

  // Stop offering items and wait until every expected output has arrived.
  task automatic drain_outputs();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending_q.size() == 0);
  endtask

  task automatic add_row(input bpf_cmd_t cmd, input int smp, input int cidx, input int cval,
                         input logic lst, input int rep, input bit typed, input int y,
                         input logic clp, input logic be);
    stim_row_t row;
    row.cmd = cmd;
    row.smp = smp[SAMPLE_BITS-1:0];
    row.cidx = cidx[CIDX_W-1:0];
    row.cval = cval[COEF_BITS-1:0];
    row.lst = lst;
    row.rep = rep;
    row.typed = typed;
    row.res = '{filtered: y[SAMPLE_BITS-1:0], clipped: clp, block_end: be};
    stim_table.push_back(row);
  endtask

  // Output checker: compare each accepted output against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected output: filtered %0d", $signed(out_tdata[SAMPLE_BITS-1:0]));
        n_errors++;
      end else begin
        fir_out_t want;
        want = pending_q.pop_front();
        n_outputs++;
        if (want.clipped) n_clipped++;
        if (want.block_end) n_block_ends++;
        if (out_tdata !== OUT_W'($unsigned(want.filtered))) begin
          $error("filtered mismatch: expected %0d, actual %0d", want.filtered,
                 $signed(out_tdata[SAMPLE_BITS-1:0]));
          n_errors++;
        end
        if (out_tuser !== want.clipped) begin
          $error("clipped mismatch: expected %0b, actual %0b", want.clipped, out_tuser);
          n_errors++;
        end
        if (out_tlast !== want.block_end) begin
          $error("block_end mismatch: expected %0b, actual %0b", want.block_end, out_tlast);
          n_errors++;
        end
      end
    end
  end

  // Receiver: random ready bursts, plus one long hold-off so the filter backs up.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && n_outputs >= HOLD_AT) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted item on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    fir_out_t no_res;
    bit       paused;
    int       sc;
    int       len;
    int       idx;
    int       cnt;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic signed [COEF_BITS-1:0]   cval;
    logic lst;

    no_res = '{filtered: '0, clipped: 1'b0, block_end: 1'b0};
    paused = 1'b0;
    for (int i = 0; i < TAPS; i++) begin
      hist_line[i] = '0;
      coef_bank[i] = '0;
    end
    window_cnt = 0;

    // Directed rows: cmd, sample, index, coefficient, last, repeat, typed, y, clip, end.
    // Fill the window from reset; all coefficients are still zero.
    add_row(CMD_SAMPLE, -32768, 0, 0, 1'b0, TAPS - 1, 1'b0, 0, 1'b0, 1'b0);
    add_row(CMD_SAMPLE, 0, 0, 0, 1'b0, 1, 1'b1, 0, 1'b0, 1'b0);
    // Extreme coefficients at tap 0 and 1 drive the sum into both rails.
    add_row(CMD_LOAD, 0, 0, 131071, 1'b0, 1, 1'b0, 0, 1'b0, 1'b0);
    add_row(CMD_LOAD, 0, 1, -131072, 1'b0, 1, 1'b0, 0, 1'b0, 1'b0);
    add_row(CMD_SAMPLE, 32767, 0, 0, 1'b0, 1, 1'b1, 32767, 1'b1, 1'b0);
    add_row(CMD_SAMPLE, -32768, 0, 0, 1'b0, 1, 1'b1, -32768, 1'b1, 1'b0);
    add_row(CMD_SAMPLE, 32767, 0, 0, 1'b1, 1, 1'b1, 32767, 1'b1, 1'b1);
    // Out-of-range tap indexes are dropped; last on a load is ignored.
    add_row(CMD_LOAD, 0, 29, 1, 1'b0, 1, 1'b0, 0, 1'b0, 1'b0);
    add_row(CMD_LOAD, -1, 31, -1, 1'b0, 1, 1'b0, 0, 1'b0, 1'b0);
    add_row(CMD_LOAD, 0, 0, 32768, 1'b1, 1, 1'b0, 0, 1'b0, 1'b0);
    add_row(CMD_LOAD, 0, 1, 0, 1'b0, 1, 1'b0, 0, 1'b0, 1'b0);
    add_row(CMD_LOAD, 0, 28, -131072, 1'b0, 1, 1'b0, 0, 1'b0, 1'b0);
    // Refill after the block end, then exact halves around zero.
    add_row(CMD_SAMPLE, 0, 0, 0, 1'b0, TAPS - 2, 1'b0, 0, 1'b0, 1'b0);
    add_row(CMD_SAMPLE, 1, 0, 0, 1'b0, 1, 1'b0, 0, 1'b0, 1'b0);
    add_row(CMD_SAMPLE, 1, 0, 0, 1'b0, 1, 1'b0, 0, 1'b0, 1'b0);
    add_row(CMD_SAMPLE, -1, 0, 0, 1'b0, 1, 1'b0, 0, 1'b0, 1'b0);
    add_row(CMD_SAMPLE, 3, 0, 0, 1'b1, 1, 1'b0, 0, 1'b0, 1'b0);
    // Block ends while the window is still short give nothing.
    add_row(CMD_SAMPLE, 5, 0, 0, 1'b1, 3, 1'b0, 0, 1'b0, 1'b0);

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[r]) begin
      for (int k = 0; k < stim_table[r].rep; k++) begin
        send_item(stim_table[r].cmd, stim_table[r].smp, stim_table[r].cidx,
                  stim_table[r].cval, stim_table[r].lst, stim_table[r].typed,
                  stim_table[r].res);
      end
    end

    // Random part: coefficient sets of varied scale mixed with sample blocks.
    while (n_items < ITEMS_TOTAL) begin
      if (n_items >= ITEMS_TOTAL - CALM_ITEMS) calm = 1'b1;
      if (!paused && n_items >= PAUSE_AT) begin
        paused = 1'b1;
        drain_outputs();
      end
      if ($urandom_range(0, 4) == 0) begin
        // Reload some or all taps, starting anywhere, with one scale per set.
        sc = $urandom_range(0, 3);
        cnt = $urandom_range(1, TAPS);
        idx = $urandom_range(0, TAPS - 1);
        for (int k = 0; k < cnt; k++) begin
          case (sc)
            0: cval = COEF_BITS'($urandom());
            1: cval = COEF_BITS'(int'($urandom_range(0, 4095)) - 2048);
            2: cval = COEF_BITS'(int'($urandom_range(0, 511)) - 256);
            default: begin
              cval = COEF_BITS'(1) << $urandom_range(0, COEF_BITS - 2);
              if ($urandom_range(0, 1)) cval = -cval;
            end
          endcase
          send_item(CMD_LOAD, SAMPLE_BITS'($urandom()), CIDX_W'((idx + k) % TAPS), cval,
                    1'($urandom_range(0, 1)), 1'b0, no_res);
        end
        if ($urandom_range(0, 2) == 0) begin
          send_item(CMD_LOAD, SAMPLE_BITS'($urandom()), CIDX_W'($urandom_range(TAPS, 31)),
                    COEF_BITS'($urandom()), 1'b0, 1'b0, no_res);
        end
      end else begin
        // One block of samples, with stray loads and early block ends as noise.
        sc = $urandom_range(0, 2);
        len = $urandom_range(20, 70);
        for (int k = 0; k < len; k++) begin
          case (sc)
            0: smp = SAMPLE_BITS'($urandom());
            1: smp = SAMPLE_BITS'(int'($urandom_range(0, 1999)) - 1000);
            default: smp = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          endcase
          lst = (k == len - 1) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 59) == 0);
          send_item(CMD_SAMPLE, smp, CIDX_W'($urandom()), COEF_BITS'($urandom()), lst,
                    1'b0, no_res);
          if ($urandom_range(0, 24) == 0) begin
            send_item(CMD_LOAD, SAMPLE_BITS'($urandom()), CIDX_W'($urandom_range(0, 31)),
                      COEF_BITS'($urandom_range(0, 255)), 1'b0, 1'b0, no_res);
          end
        end
      end
    end

    drain_outputs();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_q.size() != 0) begin
      $error("%0d expected outputs never arrived", pending_q.size());
      n_errors++;
    end

    $display("Sent %0d items (%0d coefficient loads); checked %0d filter outputs,",
             n_items, n_loads, n_outputs);
    $display("of which %0d saturated and %0d closed a block.", n_clipped, n_block_ends);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
